// File: rtl/sha_pkg.sv
// Package for the SHA-256 stream hasher: opcodes, round constants, initial
// hash values and the rotate-right helper. No dependencies.
package sha_pkg;

  typedef enum logic [1:0] {
    OP_ABSORB        = 2'd0,
    OP_ABSORB_FINISH = 2'd1,
    OP_FINISH        = 2'd2,
    OP_UNUSED        = 2'd3
  } opcode_e;

  // One queued command: an optional byte to absorb and whether a finish follows.
  typedef struct packed {
    logic       has_byte;
    logic       finish;
    logic [7:0] data;
  } cmd_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: rtl/sha_front.sv
// Front end: accepts input beats, drops the unused opcode and turns the rest
// into commands for the queue. Depends on sha_pkg.
module sha_front
  import sha_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] data_byte_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output cmd_t       cmd_o
);

  logic full_q, full_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  assign in_ready_o = !full_q || cmd_ready_i;
  assign take = in_valid_i && in_ready_o && (opcode_e'(opcode_i) != OP_UNUSED);

  always_comb begin
    full_d = full_q;
    cmd_d = cmd_q;
    if (cmd_ready_i) full_d = 1'b0;
    if (take) begin
      full_d = 1'b1;
      cmd_d.has_byte = (opcode_e'(opcode_i) != OP_FINISH);
      cmd_d.finish = (opcode_e'(opcode_i) != OP_ABSORB);
      cmd_d.data = data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else full_q <= full_d;
  end

  always_ff @(posedge clk_i) cmd_q <= cmd_d;

  assign cmd_valid_o = full_q;
  assign cmd_o = cmd_q;

endmodule

// File: rtl/sha_fifo.sv
// Two-entry command queue between the front and back ends.
// Depends on sha_pkg for the command type.
module sha_fifo
  import sha_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cmd_t wr_cmd_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cmd_t rd_cmd_o
);

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_cmd_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) if (wr) mem_q[wp_q] <= wr_cmd_i;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count beyond depth");
  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wp_q != rp_q)) else $error("pointers disagree with count");
  a_ptr_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd1) |-> (wp_q == rp_q)) else $error("pointers disagree with count");
`endif

endmodule

// File: rtl/sha_back.sv
// Back end: block buffer, padding, message schedule and the round engine.
// Depends on sha_pkg.
module sha_back
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_bits_255_192_o,
  output logic [63:0] digest_bits_191_128_o,
  output logic [63:0] digest_bits_127_64_o,
  output logic [63:0] digest_bits_63_0_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_ADD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e      state_q;
  logic [31:0] w_q [16];     // block bytes are packed straight into the window
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [5:0]  fill_q;
  logic [5:0]  rnd_q;
  logic [63:0] bits_q;
  logic [63:0] len_q;
  logic        fin_q;      // finish pending after the current compression
  logic        last_q;     // current compression is the final one
  logic        out_q;
  logic [63:0] dg_q [4];

  logic [31:0] w15, w2, wnew, wt, s1, ch, t1, s0, mj;

  always_comb begin
    w15 = w_q[1];
    w2 = w_q[14];
    wnew = w_q[0] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w_q[9]
         + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
    wt = w_q[0];
    s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + s1 + ch + ROUND_K[rnd_q] + wt;
    s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  end

  // The digest register parts the two sides: a waiting digest only holds the
  // next finish, not the absorbing of bytes.
  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_q;
  assign digest_bits_255_192_o = dg_q[0];
  assign digest_bits_191_128_o = dg_q[1];
  assign digest_bits_127_64_o = dg_q[2];
  assign digest_bits_63_0_o = dg_q[3];

  // Writes one byte at the given position of the window.
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[8*(3-pos) +: 8] = b;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q <= '0;
      bits_q <= '0;
      rnd_q <= '0;
      fin_q <= 1'b0;
      last_q <= 1'b0;
      out_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
    end else begin
      if (out_q && out_ready_i) out_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i && cmd_ready_o) begin
            fin_q <= cmd_i.finish;
            len_q <= bits_q + (cmd_i.has_byte ? 64'd8 : 64'd0);
            if (cmd_i.has_byte) begin
              w_q[fill_q[5:2]] <= put_byte(w_q[fill_q[5:2]], fill_q[1:0], cmd_i.data);
              bits_q <= bits_q + 64'd8;
              fill_q <= fill_q + 6'd1;
              if (fill_q == 6'd63) begin
                last_q <= 1'b0;
                rnd_q <= '0;
                for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
                state_q <= S_ROUND;
              end else if (cmd_i.finish) state_q <= S_PAD;
            end else state_q <= S_PAD;
          end
        end
        S_PAD: begin
          // Marker byte, zeros, then the length when it fits in this block.
          w_q[fill_q[5:2]] <= put_byte(w_q[fill_q[5:2]] & ~(32'hffffffff >> (8*fill_q[1:0])),
                                       fill_q[1:0], 8'h80);
          for (int j = 0; j < 14; j++)
            if (j > int'(fill_q[5:2])) w_q[j] <= '0;
          if (fill_q < 6'd56) begin
            w_q[14] <= len_q[63:32];
            w_q[15] <= len_q[31:0];
            last_q <= 1'b1;
            fin_q <= 1'b0;
            fill_q <= '0;
          end else begin
            for (int j = 14; j < 16; j++)
              if (j > int'(fill_q[5:2])) w_q[j] <= '0;
            last_q <= 1'b0;
            fill_q <= 6'd63;   // marks a length-only block to follow
          end
          rnd_q <= '0;
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
          w_q[15] <= wnew;
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + s0 + mj;
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) state_q <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (last_q) state_q <= S_OUT;
          else if (fin_q && fill_q == 6'd63) begin
            for (int j = 0; j < 14; j++) w_q[j] <= '0;
            w_q[14] <= len_q[63:32];
            w_q[15] <= len_q[31:0];
            last_q <= 1'b1;
            fin_q <= 1'b0;
            fill_q <= '0;
            rnd_q <= '0;
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i] + v_q[i];
            state_q <= S_ROUND;
          end else if (fin_q) begin
            fill_q <= '0;
            state_q <= S_PAD;
          end else state_q <= S_IDLE;
        end
        S_OUT: begin
          if (!out_q) begin
            for (int i = 0; i < 4; i++) dg_q[i] <= {h_q[2*i], h_q[2*i+1]};
            for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
            out_q <= 1'b1;
            last_q <= 1'b0;
            bits_q <= '0;
            fill_q <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_q && !out_ready_i) |=> $stable(dg_q[0])) else $error("digest changed while stalled");
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && rnd_q == 6'd63) |=> (state_q == S_ADD))
    else $error("round count lost");
`endif

endmodule

// File: rtl/sha256_stream_hasher_top.sv
// Channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o   | opcode_i, data_byte_i
// out     | output    | out_valid_o/out_ready_i | four 64-bit digest words
// Each full block is compressed by the single round engine, then goes through
// the chaining add. A finish adds a padding step plus one or two compressions
// and a load of the digest register. Reset is asynchronous, active low, and
// restores the initial hash values. The front end and queue keep taking
// beats while the round engine works or a stalled digest holds the next
// finish, until the front register and the two queue entries are full.
// Top level; depends on sha_pkg, sha_front, sha_fifo and sha_back.
module sha256_stream_hasher_top
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_bits_255_192_o,
  output logic [63:0] digest_bits_191_128_o,
  output logic [63:0] digest_bits_127_64_o,
  output logic [63:0] digest_bits_63_0_o
);

  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;

  sha_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .data_byte_i,
    .cmd_valid_o(f_valid), .cmd_ready_i(f_ready), .cmd_o(f_cmd));

  sha_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_cmd_i(f_cmd),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_cmd_o(b_cmd));

  sha_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(b_valid), .cmd_ready_o(b_ready), .cmd_i(b_cmd),
    .out_valid_o, .out_ready_i, .digest_bits_255_192_o, .digest_bits_191_128_o,
    .digest_bits_127_64_o, .digest_bits_63_0_o);

endmodule
